FILE: rtl/core/grid_surface_normals_top_assert.svh
// Assertion macros used by the grid normals back end.
// Expects signals named clk and rst_n in the including module.
`ifndef GRID_SURFACE_NORMALS_TOP_ASSERT_SVH
`define GRID_SURFACE_NORMALS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GSN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gsn_pkg.sv
// Shared types and constants of the grid normals block.
// No dependencies.
package gsn_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int NORM_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GW_W       = 9;
    localparam int GH_W       = 16;

    localparam logic signed [NORM_W-1:0] UNIT_Q14 = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef logic signed [DIFF_W-1:0] diff_t;

    // One unit of work for the back end: up vector or a cross product to normalize.
    typedef struct packed {
        logic  is_up;
        logic  last_row;
        diff_t u_x;
        diff_t u_y;
        diff_t u_z;
        diff_t r_x;
        diff_t r_y;
        diff_t r_z;
    } job_t;

endpackage

FILE: rtl/core/gsn_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module gsn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/gsn_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on gsn_pkg.
module gsn_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  gsn_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output gsn_pkg::job_t pop_data
);
    import gsn_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/gsn_front.sv
// Front end: accepts vertices, tracks the grid position, keeps the previous
// row in the line store and issues jobs. Depends on gsn_pkg and gsn_ram.
module gsn_front #(
    parameter int MAX_ROW_LENGTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsn_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [gsn_pkg::COORD_W-1:0] vert_x,
    input  logic signed [gsn_pkg::COORD_W-1:0] vert_y,
    input  logic signed [gsn_pkg::COORD_W-1:0] vert_z,
    output logic                              job_valid,
    input  logic                              job_ready,
    output gsn_pkg::job_t                     job_data
);
    import gsn_pkg::*;

    localparam int AW = $clog2(MAX_ROW_LENGTH);
    localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int EW = (CW > GW_W) ? CW : GW_W;
    localparam int LW = 3 * COORD_W;
    localparam logic [EW-1:0] MAX_LEN = EW'(MAX_ROW_LENGTH);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_RDA  = 5'b00010,
        F_RDB  = 5'b00100,
        F_WR   = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t             state_reg, state_next;
    logic [GW_W-1:0]     gw_reg;
    logic [GH_W-1:0]     gh_reg;
    logic [AW-1:0]       col_reg, col_next;
    logic [GH_W-1:0]     row_reg, row_next;
    logic [LW-1:0]       vtx_reg, p_reg, nxt_reg;
    logic [EW-1:0]       gw_ext, w_eff;
    logic [GH_W-1:0]     h_eff;
    logic                last_col, last_row;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [LW-1:0]       ram_rdata;
    logic                cfg_hit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == F_IDLE);
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_GRID_WIDTH) ||
                                     (cfg_index == REG_GRID_HEIGHT));

    // Clamp the configured sizes to the supported range.
    always_comb
    begin
        gw_ext = EW'(gw_reg);
        if (gw_ext < EW'(2))
        begin
            w_eff = EW'(2);
        end
        else if (gw_ext > MAX_LEN)
        begin
            w_eff = MAX_LEN;
        end
        else
        begin
            w_eff = gw_ext;
        end
        h_eff    = (gh_reg < GH_W'(2)) ? GH_W'(2) : gh_reg;
        last_col = (EW'(col_reg) + EW'(1)) >= w_eff;
        last_row = row_reg >= (h_eff - GH_W'(1));
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = col_reg;
        job_valid = 1'b0;
        state_next = state_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_RDA;
                end
            end
            F_RDA:
            begin
                ram_re     = 1'b1;
                state_next = F_RDB;
            end
            F_RDB:
            begin
                ram_re     = 1'b1;
                ram_raddr  = col_reg + AW'(1);
                state_next = F_WR;
            end
            F_WR:
            begin
                ram_we     = 1'b1;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                job_valid = (row_reg != '0);
                if (row_reg == '0 || job_ready)
                begin
                    state_next = F_IDLE;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + GH_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        // A write to any known register restarts the grid.
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        job_data.is_up    = last_col;
        job_data.last_row = last_row;
        job_data.u_x = DIFF_W'($signed(vtx_reg[3*COORD_W-1:2*COORD_W]))
                     - DIFF_W'($signed(p_reg[3*COORD_W-1:2*COORD_W]));
        job_data.u_y = DIFF_W'($signed(vtx_reg[2*COORD_W-1:COORD_W]))
                     - DIFF_W'($signed(p_reg[2*COORD_W-1:COORD_W]));
        job_data.u_z = DIFF_W'($signed(vtx_reg[COORD_W-1:0]))
                     - DIFF_W'($signed(p_reg[COORD_W-1:0]));
        job_data.r_x = DIFF_W'($signed(nxt_reg[3*COORD_W-1:2*COORD_W]))
                     - DIFF_W'($signed(p_reg[3*COORD_W-1:2*COORD_W]));
        job_data.r_y = DIFF_W'($signed(nxt_reg[2*COORD_W-1:COORD_W]))
                     - DIFF_W'($signed(p_reg[2*COORD_W-1:COORD_W]));
        job_data.r_z = DIFF_W'($signed(nxt_reg[COORD_W-1:0]))
                     - DIFF_W'($signed(p_reg[COORD_W-1:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            gw_reg    <= GW_W'(256);
            gh_reg    <= GH_W'(256);
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_valid && cfg_index == REG_GRID_WIDTH)
            begin
                gw_reg <= cfg_data[GW_W-1:0];
            end
            if (cfg_valid && cfg_index == REG_GRID_HEIGHT)
            begin
                gh_reg <= cfg_data[GH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vtx_reg <= {vert_x, vert_y, vert_z};
        end
        if (state_reg == F_RDB)
        begin
            p_reg <= ram_rdata;
        end
        if (state_reg == F_WR)
        begin
            nxt_reg <= ram_rdata;
        end
    end

    gsn_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (col_reg),
        .wr_data (vtx_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

FILE: rtl/core/gsn_back.sv
// Back end: cross product, normalizing shift, square root and divide, then
// result delivery. Depends on gsn_pkg and the assertion macro header.
`include "grid_surface_normals_top_assert.svh"

module gsn_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  gsn_pkg::job_t                     job_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gsn_pkg::NORM_W-1:0] norm_x,
    output logic signed [gsn_pkg::NORM_W-1:0] norm_y,
    output logic signed [gsn_pkg::NORM_W-1:0] norm_z,
    output logic                              run_end
);
    import gsn_pkg::*;

    localparam int PW = 2 * DIFF_W;   // product width
    localparam int AW = PW + 1;       // accumulator width
    localparam int MW = PW;           // magnitude width
    localparam int QW = 15;           // quotient width
    localparam int NW = 46;           // dividend width

    typedef enum logic [9:0] {
        B_IDLE  = 10'b0000000001,
        B_MUL   = 10'b0000000010,
        B_MAX   = 10'b0000000100,
        B_NORM  = 10'b0000001000,
        B_SQ    = 10'b0000010000,
        B_SQRT  = 10'b0000100000,
        B_DINIT = 10'b0001000000,
        B_DIV   = 10'b0010000000,
        B_OUT1  = 10'b0100000000,
        B_OUT2  = 10'b1000000000
    } bstate_t;

    bstate_t                  state_reg;
    job_t                     job_reg;
    logic [3:0]               step_reg;
    logic signed [AW-1:0]     acc_reg;
    logic [MW-1:0]            mag_reg [3];
    logic [2:0]               neg_reg;
    logic [MW-1:0]            m_reg;
    logic [61:0]              s_reg;
    logic [63:0]              rem_reg, res_reg, bit_reg;
    logic [NW-1:0]            num_reg [3];
    logic [NW-1:0]            dsh_reg;
    logic [QW-1:0]            q_reg [3];
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic                     run_end_reg;

    logic signed [DIFF_W-1:0] op_a, op_b;
    logic                     op_neg;
    logic signed [PW-1:0]     prod;
    logic signed [AW-1:0]     sum, sum_abs;
    logic [MW-1:0]            max01, max3;
    logic [MW-1:0]            sq_sel;
    logic [59:0]              sq;
    logic [63:0]              rb;
    logic [QW-1:0]            q_next [3];
    logic [NW-1:0]            num_next [3];
    logic [NW-1:0]            lshift;

    assign job_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT1) || (state_reg == B_OUT2);
    assign norm_x    = nx_reg;
    assign norm_y    = ny_reg;
    assign norm_z    = nz_reg;
    assign run_end   = run_end_reg;

    // Shared multiplier walks the six cross-product terms.
    always_comb
    begin
        case (step_reg)
            4'd0:    begin op_a = job_reg.u_y; op_b = job_reg.r_z; op_neg = 1'b0; end
            4'd1:    begin op_a = job_reg.u_z; op_b = job_reg.r_y; op_neg = 1'b1; end
            4'd2:    begin op_a = job_reg.u_z; op_b = job_reg.r_x; op_neg = 1'b0; end
            4'd3:    begin op_a = job_reg.u_x; op_b = job_reg.r_z; op_neg = 1'b1; end
            4'd4:    begin op_a = job_reg.u_x; op_b = job_reg.r_y; op_neg = 1'b0; end
            4'd5:    begin op_a = job_reg.u_y; op_b = job_reg.r_x; op_neg = 1'b1; end
            default: begin op_a = '0;          op_b = '0;          op_neg = 1'b0; end
        endcase
        prod    = op_a * op_b;
        sum     = op_neg ? (acc_reg - AW'(prod)) : (acc_reg + AW'(prod));
        sum_abs = (sum < 0) ? -sum : sum;
    end

    always_comb
    begin
        max01  = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max3   = (max01 > mag_reg[2]) ? max01 : mag_reg[2];
        case (step_reg)
            4'd0:    sq_sel = mag_reg[0];
            4'd1:    sq_sel = mag_reg[1];
            default: sq_sel = mag_reg[2];
        endcase
        sq     = sq_sel[29:0] * sq_sel[29:0];
        rb     = res_reg + bit_reg;
        lshift = NW'(res_reg[31:0]) << 14;
        for (int i = 0; i < 3; i++)
        begin
            if (num_reg[i] >= dsh_reg)
            begin
                num_next[i] = num_reg[i] - dsh_reg;
                q_next[i]   = {q_reg[i][QW-2:0], 1'b1};
            end
            else
            begin
                num_next[i] = num_reg[i];
                q_next[i]   = {q_reg[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            step_reg    <= '0;
            run_end_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        step_reg    <= '0;
                        run_end_reg <= ~job_data.last_row;
                        state_reg   <= job_data.is_up ? B_OUT1 : B_MUL;
                    end
                end
                B_MUL:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd5)
                    begin
                        state_reg <= B_MAX;
                    end
                end
                B_MAX:
                begin
                    state_reg <= B_NORM;
                end
                B_NORM:
                begin
                    step_reg <= '0;
                    if (m_reg == '0)
                    begin
                        state_reg <= B_OUT1;
                    end
                    else if (m_reg[MW-1:30] == '0 && m_reg[29])
                    begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd2)
                    begin
                        state_reg <= B_SQRT;
                    end
                end
                B_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= B_DINIT;
                    end
                end
                B_DINIT:
                begin
                    step_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(QW - 1))
                    begin
                        state_reg <= B_OUT1;
                    end
                end
                B_OUT1:
                begin
                    if (out_ready)
                    begin
                        if (job_reg.last_row)
                        begin
                            run_end_reg <= 1'b1;
                            state_reg   <= B_OUT2;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                B_OUT2:
                begin
                    if (out_ready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg <= job_data;
                acc_reg <= '0;
                nx_reg  <= '0;
                ny_reg  <= '0;
                nz_reg  <= job_data.is_up ? UNIT_Q14 : '0;
            end
            B_MUL:
            begin
                if (step_reg[0])
                begin
                    mag_reg[step_reg[2:1]] <= sum_abs[MW-1:0];
                    neg_reg[step_reg[2:1]] <= sum[AW-1];
                    acc_reg                <= '0;
                end
                else
                begin
                    acc_reg <= sum;
                end
            end
            B_MAX:
            begin
                m_reg <= max3;
            end
            B_NORM:
            begin
                s_reg <= '0;
                // Step all magnitudes one bit toward the target window.
                if (m_reg[MW-1:30] != '0)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (!m_reg[29])
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            B_SQ:
            begin
                s_reg <= s_reg + 62'(sq);
                if (step_reg == 4'd2)
                begin
                    rem_reg <= 64'(s_reg) + 64'(sq);
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                end
            end
            B_SQRT:
            begin
                if (rem_reg >= rb)
                begin
                    rem_reg <= rem_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            B_DINIT:
            begin
                dsh_reg <= lshift;
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[i] <= {2'b00, mag_reg[i][29:0], 14'b0} + NW'(res_reg[31:1]);
                    q_reg[i]   <= '0;
                end
            end
            B_DIV:
            begin
                dsh_reg <= dsh_reg >> 1;
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[i] <= num_next[i];
                    q_reg[i]   <= q_next[i];
                end
                if (step_reg == 4'(QW - 1))
                begin
                    nx_reg <= neg_reg[0] ? -NORM_W'(q_next[0]) : NORM_W'(q_next[0]);
                    ny_reg <= neg_reg[1] ? -NORM_W'(q_next[1]) : NORM_W'(q_next[1]);
                    nz_reg <= neg_reg[2] ? -NORM_W'(q_next[2]) : NORM_W'(q_next[2]);
                end
            end
            B_OUT1:
            begin
                if (out_ready)
                begin
                    nx_reg <= '0;
                    ny_reg <= '0;
                    nz_reg <= UNIT_Q14;
                end
            end
            default:
            begin
            end
        endcase
    end

    `GSN_ASSERT_NOW(a_norm_window, state_reg == B_SQ,
        m_reg[MW-1:30] == '0 && m_reg[29], "largest magnitude outside target window")
    `GSN_ASSERT_NOW(a_len_range, state_reg == B_DINIT,
        res_reg[63:31] == '0 && (res_reg[30] || res_reg[29]), "length out of range")
    `GSN_ASSERT_NOW(a_second_word, state_reg == B_OUT2,
        job_reg.last_row && run_end_reg, "second word outside the last row")

endmodule

FILE: rtl/core/grid_surface_normals_top.sv
// Top level of the grid surface normals block.
// Depends on gsn_pkg, gsn_front, gsn_queue and gsn_back.
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//  in        in         in_valid/in_ready      vert_x, vert_y, vert_z
//  out       out        out_valid/out_ready    norm_x, norm_y, norm_z, run_end
//
// The front end handles one vertex at a time: two line-store reads of
// the single read port, one write, then the job push, before the next.
// In the back end a normal passes through six multiply steps, one bit of
// normalizing shift per cycle, three squares, 32 square-root steps and
// 15 divide steps; the up vector goes straight to result delivery.
// A two-entry job queue lets the front keep filling the line store while the
// back end stalls on out_ready; a full queue holds in_ready low.
// Reset clears control state only; the line store has no clearing pass.
module grid_surface_normals_top #(
    parameter int MAX_ROW_LENGTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gsn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsn_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [gsn_pkg::COORD_W-1:0] vert_x,
    input  logic signed [gsn_pkg::COORD_W-1:0] vert_y,
    input  logic signed [gsn_pkg::COORD_W-1:0] vert_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gsn_pkg::NORM_W-1:0]  norm_x,
    output logic signed [gsn_pkg::NORM_W-1:0]  norm_y,
    output logic signed [gsn_pkg::NORM_W-1:0]  norm_z,
    output logic                               run_end
);
    import gsn_pkg::*;

    // Jobs from the front end into the queue.
    logic push_valid, push_ready;
    job_t push_data;
    // Jobs from the queue into the back end.
    logic pop_valid, pop_ready;
    job_t pop_data;

    gsn_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .vert_z    (vert_z),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    gsn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    gsn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .run_end   (run_end)
    );

endmodule

FILE: dv/gsn_scoreboard.sv
// Scoreboard for the grid surface normals block: tracks the grid position and the line store,
// and predicts the normals each accepted vertex causes. Depends on gsn_pkg.
class gsn_scoreboard;

    typedef struct {
        logic signed [gsn_pkg::NORM_W-1:0] nx;
        logic signed [gsn_pkg::NORM_W-1:0] ny;
        logic signed [gsn_pkg::NORM_W-1:0] nz;
        logic                              last;
    } normal_t;

    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned col_pos;
    int unsigned row_pos;
    longint      row_x[256];
    longint      row_y[256];
    longint      row_z[256];
    normal_t     normals_due[$];
    int          errors;
    int          results_seen;

    function new();
        width_reg = 256;
        height_reg = 256;
        col_pos = 0;
        row_pos = 0;
        errors = 0;
        results_seen = 0;
    endfunction

    task report(string what);
        $display("MISMATCH %0t: %s", $realtime, what);
        errors++;
    endtask

    function int pending();
        return normals_due.size();
    endfunction

    function void write_reg(logic [gsn_pkg::CFG_IDX_W-1:0] idx,
                            logic [gsn_pkg::CFG_DATA_W-1:0] data);
        if (idx == gsn_pkg::REG_GRID_WIDTH)
            width_reg = data[gsn_pkg::GW_W-1:0];
        else if (idx == gsn_pkg::REG_GRID_HEIGHT)
            height_reg = data;
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function normal_t unit_normal(longint c[3]);
        normal_t         n;
        longint unsigned mag[3];
        longint unsigned m, s, len, q;
        longint          comp[3];
        int              nbits;
        m = 0;
        s = 0;
        nbits = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            n.nx = 0; n.ny = 0; n.nz = 0;
            return n;
        end
        while (nbits < 64 && (m >> nbits) != 0) nbits++;
        for (int i = 0; i < 3; i++) begin
            if (nbits > 30) mag[i] >>= (nbits - 30);
            else mag[i] <<= (30 - nbits);
            s += mag[i] * mag[i];
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + len / 2) / len;
            comp[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        n.nx = 16'(comp[0]); n.ny = 16'(comp[1]); n.nz = 16'(comp[2]);
        return n;
    endfunction

    function void note_vertex(logic signed [23:0] vx, logic signed [23:0] vy,
                              logic signed [23:0] vz);
        int unsigned w, h, col;
        bit          last_row;
        normal_t     n, up;
        longint      ux, uy, uz, rx, ry, rz;
        longint      c[3];
        w = width_reg < 2 ? 2 : (width_reg > 256 ? 256 : width_reg);
        h = height_reg < 2 ? 2 : height_reg;
        col = col_pos >= w ? w - 1 : col_pos;
        last_row = row_pos >= h - 1;
        up.nx = 0; up.ny = 0; up.nz = gsn_pkg::UNIT_Q14; up.last = 1;
        if (row_pos > 0) begin
            if (col >= w - 1) begin
                n = up;
            end else begin
                ux = longint'(vx) - row_x[col];
                uy = longint'(vy) - row_y[col];
                uz = longint'(vz) - row_z[col];
                rx = row_x[col+1] - row_x[col];
                ry = row_y[col+1] - row_y[col];
                rz = row_z[col+1] - row_z[col];
                c[0] = uy * rz - uz * ry;
                c[1] = uz * rx - ux * rz;
                c[2] = ux * ry - uy * rx;
                n = unit_normal(c);
            end
            n.last = !last_row;
            normals_due.push_back(n);
            if (last_row) normals_due.push_back(up);
        end
        row_x[col] = vx;
        row_y[col] = vy;
        row_z[col] = vz;
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = last_row ? 0 : (row_pos + 1) & 16'hFFFF;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    task check_normal(logic signed [15:0] nx, logic signed [15:0] ny,
                      logic signed [15:0] nz, logic last);
        normal_t e;
        results_seen++;
        if (normals_due.size() == 0) begin
            report($sformatf("unexpected normal (%0d,%0d,%0d) end=%0d", nx, ny, nz, last));
            return;
        end
        e = normals_due.pop_front();
        if (nx !== e.nx || ny !== e.ny || nz !== e.nz || last !== e.last)
            report($sformatf("normal got (%0d,%0d,%0d) end=%0d want (%0d,%0d,%0d) end=%0d",
                             nx, ny, nz, last, e.nx, e.ny, e.nz, e.last));
    endtask

endclass

FILE: dv/grid_surface_normals_top_test.sv
// Self-checking testbench of grid_surface_normals_top: directed and random vertex grids.
// Depends on gsn_pkg and the scoreboard class in gsn_scoreboard.sv.
module grid_surface_normals_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsn_pkg::*;

    // Indexes with no register behind them; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int DRAIN_CYCLES = 250;
    localparam int STALL_LIMIT  = 5000;
    localparam int TOTAL_ITEMS  = 1050;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [COORD_W-1:0] vert_x = '0, vert_y = '0, vert_z = '0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
    logic run_end;

    gsn_scoreboard sb = new();
    int  words_in = 0;
    int  reg_writes = 0;
    int  grids_run = 0;
    int  quiet_cycles = 0;
    bit  quiet = 0;        // final stretch: no idling on either side
    int  stall_left = 0;

    grid_surface_normals_top DUT (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Receiver: stall out_ready in random bursts, hold it high once quiet.
    always @(posedge clk)
    begin
        if (quiet) begin
            out_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_ready <= 0;
        end else begin
            out_ready <= 1;
        end
    end

    // Check every accepted normal against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_normal(norm_x, norm_y, norm_z, run_end);
    end

    // Watchdog: too many cycles without any word moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("grid_surface_normals_top regression: fail");
                $finish;
            end
        end
    end

    // Drain all pending normals, then let the front end and job queue settle.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        reg_writes++;
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_vertex(logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] z);
        // Drop idling on both sides for the last part of the run.
        if (words_in > TOTAL_ITEMS * 85 / 100) quiet = 1;
        // Random gap on the sender side; none in the final stretch.
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1;
        vert_x <= x;
        vert_y <= y;
        vert_z <= z;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_vertex(x, y, z);
        words_in++;
    endtask

    // Pick a coordinate word by style: full random, heightfield, tiny, or extreme.
    function automatic logic signed [23:0] pick_coord(int style, int grid_pos, int step);
        logic signed [23:0] corner[4];
        corner = '{24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sd1};
        case (style)
            0: return $urandom;
            1: return grid_pos * step;
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return corner[$urandom_range(0, 3)];
        endcase
    endfunction

    task automatic run_grid(int items, int w_eff, int style);
        int step;
        int col, row;
        step = $urandom_range(1, 16384);
        for (int i = 0; i < items; i++) begin
            col = i % w_eff;
            row = (i / w_eff) % 256;
            if (style == 1)
                send_vertex(pick_coord(1, col, step), pick_coord(1, row, step),
                            $signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            else
                send_vertex(pick_coord(style, 0, 0), pick_coord(style, 0, 0),
                            pick_coord(style, 0, 0));
        end
        drain();
        grids_run++;
    endtask

    initial
    begin
        int w_data, h_data, w_eff, h_eff, items;

        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset widths (256 x 256): fill the first row and emit a few normals.
        run_grid(260, 256, 0);

        // Directed: 3 x 2 grid with extreme corners, then a flat patch, then wrap.
        write_reg(REG_GRID_WIDTH, 16'd3);
        write_reg(REG_GRID_HEIGHT, 16'd2);
        send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_vertex(-24'sh800000, -24'sh800000, -24'sh800000);
        send_vertex(24'sd0, 24'sd0, 24'sd0);
        send_vertex(-24'sh800000, 24'sh7FFFFF, -24'sh800000);
        send_vertex(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
        send_vertex(24'sd5, 24'sd5, 24'sd5);
        // Coincident vertices: zero-length cross product.
        repeat (6) send_vertex(24'sd77, -24'sd9, 24'sd1000);
        // Flat plane in z: normal straight down (-z); second grid after the wrap.
        for (int i = 0; i < 6; i++)
            send_vertex((i % 3) * 100, (i / 3) * 100, 24'sd42);
        drain();

        // Dropped writes to unused indexes must not restart the grid.
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        for (int i = 0; i < 6; i++)
            send_vertex(i * 3, -i * 7, i * i);
        drain();

        while (words_in < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w_data = $urandom_range(0, 1);
                1: w_data = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                2: w_data = $urandom;          // high bits ignored by the register
                default: w_data = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 9))
                0: h_data = $urandom_range(0, 1);
                1: h_data = $urandom_range(0, 1) ? 65535 : $urandom;
                default: h_data = $urandom_range(2, 5);
            endcase
            if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_WIDTH, w_data);
            if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_HEIGHT, h_data);
            w_eff = sb.width_reg < 2 ? 2 : (sb.width_reg > 256 ? 256 : sb.width_reg);
            h_eff = sb.height_reg < 2 ? 2 : sb.height_reg;
            items = w_eff * h_eff * $urandom_range(1, 2);
            if (items > 300) items = w_eff * ($urandom_range(0, 3) == 0 ? 2 : 1) + w_eff / 2;
            if (items > 600) items = 600;
            if (items > TOTAL_ITEMS - words_in) items = TOTAL_ITEMS - words_in;
            run_grid(items, w_eff, $urandom_range(0, 3));
        end

        drain();
        $display("covered %0d vertices, %0d normals, %0d register writes, %0d grids",
                 words_in, sb.results_seen, reg_writes, grids_run);
        $display("widths 0..511 and heights 0..65535 incl. clamps, wraps and flat patches");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("grid_surface_normals_top regression: pass");
        else
            $display("grid_surface_normals_top regression: fail");
        $finish;
    end

endmodule
